/* rtl/crossing_period_averager_top_assert.svh */
// ----------------------------------------------------------------------------
// crossing period averager assertion macros
// shared checking shorthands for the averager rtl
// ----------------------------------------------------------------------------
`ifndef CROSSING_PERIOD_AVERAGER_TOP_ASSERT_SVH
`define CROSSING_PERIOD_AVERAGER_TOP_ASSERT_SVH

// condition must hold at every edge out of reset
`define CPA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cpa_pkg.sv */
// ----------------------------------------------------------------------------
// crossing period averager package
// fixed field widths of the averager ports
// ----------------------------------------------------------------------------
package cpa_pkg;

  // sample field width
  localparam int SAMPLE_W = 24;
  // average period field width
  localparam int AVG_W = 18;
  // fraction bits of the average (sixteenths of a sample)
  localparam int FRAC_W = 4;

endpackage

/* rtl/crossing_period_averager_top.sv */
// ----------------------------------------------------------------------------
// crossing period averager
// period estimate from level changes of a clipped wave, with moving average
// ----------------------------------------------------------------------------
// usage
//   input channel: sample_valid / sample_ready / sample, one signed sample
//   per item. output channel: average_valid / average_ready / average_period,
//   exactly one result item for every input item, in order.
//   the accepting edge updates the state and loads the running sum and stage
//   one; the divide then loads the output register from stage one once that
//   register is empty or being taken.
//   throughput: one item per cycle; sample_ready stays high while the output
//   register is empty or being taken, so items flow back to back.
//   stall: when average_ready is low the result holds in the output register,
//   the item behind it waits in the first stage, and sample_ready drops only
//   once both are full.
//   reset: rst clears the position counter, crossing flag, history ring,
//   running sum and both valid flags; the first result after reset averages
//   an all-zero history.
//   average_period is the sum of the history entries times 16 divided by
//   HISTORY_DEPTH, truncated toward zero and reduced to its field width.
// ----------------------------------------------------------------------------
`include "crossing_period_averager_top_assert.svh"

module crossing_period_averager_top #(
  parameter int WRAP_LENGTH   = 4096,
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [cpa_pkg::SAMPLE_W-1:0] sample,
  output logic                                average_valid,
  input  logic                                average_ready,
  output logic signed [cpa_pkg::AVG_W-1:0]    average_period
);

  import cpa_pkg::*;

  // position counter, history entry, slot and running sum widths
  localparam int POS_W   = $clog2(WRAP_LENGTH);
  localparam int ENTRY_W = POS_W + 2;
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W   = ENTRY_W + $clog2(HISTORY_DEPTH);
  // scaled magnitude and reciprocal for the constant divide
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int DIV_S   = NUM_W + $clog2(HISTORY_DEPTH);
  localparam int QX_W    = NUM_W + AVG_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [NUM_W:0] RECIP = RECIP_FULL[NUM_W:0];
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WRAP_LENGTH - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  // ---------------------------------------------------------------- handshake
  logic s1_valid;
  logic s2_load;
  logic accept;
  logic out_fire;

  // the divide stage loads whenever the output register is free or draining
  assign out_fire     = average_valid && average_ready;
  assign s2_load      = s1_valid && (!average_valid || average_ready);
  assign sample_ready = !s1_valid || s2_load;
  assign accept       = sample_valid && sample_ready;

  // ------------------------------------------------------------ state update
  logic [SAMPLE_W-1:0]              previous_sample;
  logic [POS_W-1:0]                 write_position;
  logic                             crossings_seen;
  logic [POS_W-1:0]                 first_position;
  logic signed [ENTRY_W-1:0]        period_history [HISTORY_DEPTH];
  logic [SLOT_W-1:0]                history_slot;
  logic signed [SUM_W-1:0]          period_sum;

  logic                             crossing;
  logic                             second;
  logic signed [POS_W:0]            pos_diff;
  logic signed [ENTRY_W-1:0]        entry_new;
  logic signed [ENTRY_W-1:0]        entry_old;
  logic signed [SUM_W-1:0]          period_sum_next;
  logic [POS_W-1:0]                 write_position_next;
  logic [SLOT_W-1:0]                history_slot_next;

  // a crossing is a change of level at any position but zero
  assign crossing = (write_position != '0) && (sample != previous_sample);
  assign second   = crossing && crossings_seen;

  // twice the signed distance between the two crossings; goes negative when
  // the position wrapped in between
  assign pos_diff  = $signed({1'b0, write_position}) - $signed({1'b0, first_position});
  assign entry_new = {pos_diff, 1'b0};
  assign entry_old = period_history[history_slot];

  // running sum follows the ring: drop the overwritten entry, add the new one
  assign period_sum_next = period_sum + SUM_W'(entry_new) - SUM_W'(entry_old);

  always_comb begin
    if (second) begin
      write_position_next = '0;
    end else if (write_position == POS_LAST) begin
      write_position_next = '0;
    end else begin
      write_position_next = write_position + 1'b1;
    end
  end

  assign history_slot_next = (history_slot == SLOT_LAST) ? '0 : history_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      write_position  <= '0;
      crossings_seen  <= 1'b0;
      first_position  <= '0;
      history_slot    <= '0;
      period_sum      <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        period_history[i] <= '0;
      end
    end else if (accept) begin
      previous_sample <= sample;
      write_position  <= write_position_next;
      if (second) begin
        crossings_seen               <= 1'b0;
        period_history[history_slot] <= entry_new;
        history_slot                 <= history_slot_next;
        period_sum                   <= period_sum_next;
      end else if (crossing) begin
        crossings_seen <= 1'b1;
        first_position <= write_position;
      end
    end
  end

  // stage one holds the sum as it stands after its item
  logic signed [SUM_W-1:0] s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sum <= second ? period_sum_next : period_sum;
    end
  end

  // ------------------------------------------------------------- divide stage
  // truncating divide of 16 * sum by the depth: magnitude times a rounded-up
  // reciprocal, shifted down, sign put back
  logic                       sum_neg;
  logic [SUM_W-1:0]           sum_mag;
  logic [NUM_W-1:0]           numer;
  logic [2*NUM_W:0]           product;
  logic [2*NUM_W:0]           shifted;
  logic [QX_W-1:0]            quot_ext;
  logic [QX_W-1:0]            quot_signed;
  logic signed [AVG_W-1:0]    average_period_next;

  assign sum_neg     = s1_sum[SUM_W-1];
  assign sum_mag     = sum_neg ? SUM_W'(-s1_sum) : SUM_W'(s1_sum);
  assign numer       = {sum_mag, {FRAC_W{1'b0}}};
  assign product     = (2*NUM_W+1)'(numer) * (2*NUM_W+1)'(RECIP);
  assign shifted     = product >> DIV_S;
  assign quot_ext    = QX_W'(shifted[NUM_W-1:0]);
  assign quot_signed = sum_neg ? (~quot_ext + 1'b1) : quot_ext;
  assign average_period_next = $signed(quot_signed[AVG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (s2_load) begin
      average_valid <= 1'b1;
    end else if (out_fire) begin
      average_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      average_period <= average_period_next;
    end
  end

  // ---------------------------------------------------------------- checks
  `CPA_ASSERT_ALWAYS(a_pos_range, write_position <= POS_LAST, "write position past wrap")
  `CPA_ASSERT_ALWAYS(a_slot_range, history_slot <= SLOT_LAST, "history slot out of range")
  `CPA_ASSERT_NEXT(a_second_clears, accept && second, write_position == '0 && !crossings_seen, "second crossing did not restart the count")
  `CPA_ASSERT_NEXT(a_s1_holds, s1_valid && average_valid && !average_ready, s1_valid && $stable(s1_sum), "stage one lost its item under stall")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossing period averager testbench
// drives sample items with bursty valid, stalls the result side on a pattern,
// and checks every average against a cycle-free model of the period tracker
// ----------------------------------------------------------------------------
module tb_top;

  import cpa_pkg::*;

  // block configuration, kept at the defaults
  localparam int WRAP_LEN   = 4096;
  localparam int RING_DEPTH = 5;
  // total items: the directed opening plus random waveform items
  localparam int TOTAL_ITEMS = 950;

  logic clk;
  logic rst = 1'b1;

  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       average_valid;
  logic                       average_ready = 1'b0;
  logic signed [AVG_W-1:0]    average_period;

  crossing_period_averager_top #(
    .WRAP_LENGTH  (WRAP_LEN),
    .HISTORY_DEPTH(RING_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .average_valid (average_valid),
    .average_ready (average_ready),
    .average_period(average_period)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // period tracker model: level-change detector, position counter and the
  // ring of doubled period lengths, advanced once per accepted item
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] last_level = '0;
  int                  pos_count  = 0;
  bit                  armed      = 1'b0;
  int                  first_pos  = 0;
  logic signed [13:0]  period_ring [RING_DEPTH] = '{default: '0};
  int                  ring_slot  = 0;

  // averages still owed by the block, oldest first
  logic signed [AVG_W-1:0] expected_averages [$];

  task automatic track_sample(input logic [SAMPLE_W-1:0] level);
    bit closed;
    int diff;
    int ring_sum;
    int mean16;
    closed = 1'b0;
    // position zero is never tested for a level change
    if (pos_count != 0 && level != last_level) begin
      if (!armed) begin
        armed     = 1'b1;
        first_pos = pos_count;
      end else begin
        closed = 1'b1;
      end
    end
    last_level = level;
    if (closed) begin
      // negative when the position wrapped between the two crossings
      diff = pos_count - first_pos;
      period_ring[ring_slot] = 14'(diff * 2);
      ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      pos_count = 0;
      armed     = 1'b0;
    end else begin
      pos_count = (pos_count == WRAP_LEN - 1) ? 0 : pos_count + 1;
    end
    ring_sum = 0;
    for (int i = 0; i < RING_DEPTH; i++)
      ring_sum += period_ring[i];
    // signed divide truncates toward zero
    mean16 = (ring_sum * 16) / RING_DEPTH;
    expected_averages.push_back(AVG_W'(mean16));
  endtask

  // --------------------------------------------------------------------------
  // stimulus store
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample_items [$];

  // hand-traced opening sequence; starts from the reset state and ends
  // right after a second crossing, so the position is back at zero
  logic [SAMPLE_W-1:0] directed_samples [23] = '{
    24'h800000,  // change at position zero, ignored
    24'h800000,
    24'h7fffff,  // first crossing, full-swing step
    24'h7fffff,
    24'h800000,  // second crossing, period 2
    24'h000000,  // change right after a second crossing, ignored
    24'h000001,  // single-bit change arms
    24'h000000,  // period 1
    24'hffffff,
    24'hffffff,
    24'hffffff,
    24'h555555,
    24'haaaaaa,
    24'haaaaaa,
    24'h555555,
    24'h555555,
    24'h555555,
    24'h555555,
    24'haaaaaa,  // fourth ring entry
    24'h123456,
    24'h123457,
    24'h123457,
    24'h123456   // last ring slot filled, the next period overwrites the oldest
  };

  task automatic hold_level(input logic [SAMPLE_W-1:0] level, input int count);
    repeat (count) sample_items.push_back(level);
  endtask

  task automatic pick_levels(output logic [SAMPLE_W-1:0] lvl_a,
                             output logic [SAMPLE_W-1:0] lvl_b);
    if ($urandom_range(0, 7) == 0) begin
      lvl_a = 24'h7fffff;
      lvl_b = 24'h800000;
    end else begin
      lvl_a = SAMPLE_W'($urandom);
      lvl_b = SAMPLE_W'($urandom);
      while (lvl_b == lvl_a) lvl_b = SAMPLE_W'($urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of items separated by random gaps; every accepted item
  // is fed to the tracker model at the edge that takes it
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      sample       <= '0;
      burst_left = $urandom_range(1, 32);
      gap_left   = 0;
    end else begin
      if (sample_valid && sample_ready)
        track_sample(sample);
      // the slot is free when nothing is shown or the shown item was taken
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0 || sample_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          sample_valid <= 1'b0;
        end else begin
          sample_valid <= 1'b1;
          sample       <= sample_items.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: ready follows the bits of a 16-bit pattern, redrawn each window;
  // some windows never stall
  // --------------------------------------------------------------------------
  logic [15:0] stall_bits  = 16'hffff;
  logic [3:0]  stall_phase = '0;

  always @(posedge clk) begin
    if (rst) begin
      average_ready <= 1'b0;
      stall_bits  = 16'hffff;
      stall_phase = '0;
    end else begin
      average_ready <= stall_bits[stall_phase];
      stall_phase = stall_phase + 4'd1;
      if (stall_phase == 4'd0) begin
        case ($urandom_range(0, 3))
          0:       stall_bits = 16'hffff;
          1:       stall_bits = 16'($urandom);
          default: stall_bits = 16'($urandom | $urandom);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every taken average against the oldest owed one
  // --------------------------------------------------------------------------
  int                      error_count  = 0;
  int                      result_count = 0;
  logic signed [AVG_W-1:0] owed_average;

  always @(posedge clk) begin
    if (!rst && average_valid && average_ready) begin
      if (expected_averages.size() == 0) begin
        if (error_count < 10)
          $display("average_period %0d arrived with no item outstanding", average_period);
        error_count++;
      end else begin
        owed_average = expected_averages.pop_front();
        if (average_period !== owed_average) begin
          if (error_count < 10)
            $display("average_period mismatch on item %0d: expected %0d, got %0d",
                     result_count, owed_average, average_period);
          error_count++;
        end
        result_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  int cycle_count = 0;
  int cycle_limit = 2000000;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence: build all items, release reset, drain, report
  // --------------------------------------------------------------------------
  initial begin : run
    logic [SAMPLE_W-1:0] lvl_a;
    logic [SAMPLE_W-1:0] lvl_b;
    int                  half;
    int                  shape;

    foreach (directed_samples[i]) sample_items.push_back(directed_samples[i]);

    // random part: mostly square waves with random levels and half periods,
    // the rest per-item noise and single-item glitches
    while (sample_items.size() < TOTAL_ITEMS) begin
      pick_levels(lvl_a, lvl_b);
      shape = $urandom_range(0, 19);
      if (shape < 14) begin
        half = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                           : $urandom_range(1, 12);
        repeat ($urandom_range(1, 4)) begin
          hold_level(lvl_a, half);
          hold_level(lvl_b, half);
        end
      end else if (shape < 17) begin
        repeat ($urandom_range(1, 8)) hold_level(SAMPLE_W'($urandom), 1);
      end else begin
        half = $urandom_range(2, 16);
        hold_level(lvl_a, half);
        hold_level(lvl_b, 1);
        hold_level(lvl_a, half);
      end
    end
    // cut the last waveform short to keep the item count
    while (sample_items.size() > TOTAL_ITEMS) void'(sample_items.pop_back());

    // worst case per item: sender gap plus a full stalled window, with margin
    cycle_limit = sample_items.size() * 100 + 10000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sample_items.size() != 0 || sample_valid) @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
    // two-stage pipeline; spare edges to catch any extra result
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
